/* hw/rtl/smse_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smse_pkg
// shared types and constants of the sticky modifier scan code emitter
// ----------------------------------------------------------------------------
package smse_pkg;

  localparam int NUM_KEYS      = 128;
  localparam int MAX_MODIFIERS = 8;

  localparam int KEY_AW  = $clog2(NUM_KEYS);
  localparam int LIST_AW = (MAX_MODIFIERS > 1) ? $clog2(MAX_MODIFIERS) : 1;
  localparam int CNT_W   = $clog2(MAX_MODIFIERS + 1);

  localparam logic [7:0] BREAK_BIT = 8'h80;

  localparam logic ACT_PRESS   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  localparam logic [1:0] KT_ORDINARY   = 2'd0;
  localparam logic [1:0] KT_TOGGLEABLE = 2'd1;
  localparam logic [1:0] KT_MODIFIER   = 2'd2;
  localparam logic [1:0] KT_SPARE      = 2'd3;

  localparam logic [1:0] KS_IDLE    = 2'd0;
  localparam logic [1:0] KS_PRESSED = 2'd1;
  localparam logic [1:0] KS_LOCKED  = 2'd2;

  typedef struct packed {
    logic       action;
    logic [6:0] key_index;
    logic [1:0] key_type;
    logic [6:0] scan_code;
    logic [7:0] prefix_code;
  } in_item_t;

  typedef struct packed {
    logic       code_valid;
    logic [7:0] code_byte;
    logic       last_of_run;
    logic [1:0] key_state_out;
    logic       list_full;
  } out_item_t;

  typedef struct packed {
    logic [7:0] prefix_code;
    logic [6:0] scan_code;
    logic [6:0] key_index;
  } mod_entry_t;

  typedef enum logic [1:0] {
    LOP_NONE,
    LOP_SET,
    LOP_APPEND,
    LOP_REMOVE
  } list_op_e;

  typedef struct packed {
    list_op_e           op;
    logic [LIST_AW-1:0] pos;
    mod_entry_t         entry;
  } list_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0]   count;
    logic               hit;
    logic [LIST_AW-1:0] hit_pos;
  } list_status_t;

endpackage

/* hw/rtl/smse_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smse_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module smse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* hw/rtl/smse_mod_list.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smse_mod_list
// ordered list of engaged modifiers with lookup, update, append and removal
// ----------------------------------------------------------------------------
module smse_mod_list (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  smse_pkg::list_cmd_t         cmd_i,
  input  logic [6:0]                  find_key_i,
  input  logic [smse_pkg::LIST_AW-1:0] rd_pos_i,
  output smse_pkg::mod_entry_t        rd_entry_o,
  output smse_pkg::list_status_t      status_o
);

  smse_pkg::mod_entry_t           list_q [smse_pkg::MAX_MODIFIERS];
  logic [smse_pkg::CNT_W-1:0]     count_q;
  logic                           hit;
  logic [smse_pkg::LIST_AW-1:0]   hit_pos;

  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int j = smse_pkg::MAX_MODIFIERS - 1; j >= 0; j--) begin
      if ((smse_pkg::CNT_W'(j) < count_q) && (list_q[j].key_index == find_key_i)) begin
        hit     = 1'b1;
        hit_pos = smse_pkg::LIST_AW'(j);
      end
    end
  end

  assign rd_entry_o       = list_q[rd_pos_i];
  assign status_o.count   = count_q;
  assign status_o.hit     = hit;
  assign status_o.hit_pos = hit_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      unique case (cmd_i.op)
        smse_pkg::LOP_APPEND: count_q <= count_q + 1'b1;
        smse_pkg::LOP_REMOVE: count_q <= count_q - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      smse_pkg::LOP_SET: begin
        list_q[cmd_i.pos] <= cmd_i.entry;
      end
      smse_pkg::LOP_APPEND: begin
        list_q[smse_pkg::LIST_AW'(count_q)] <= cmd_i.entry;
      end
      smse_pkg::LOP_REMOVE: begin
        for (int j = 0; j < smse_pkg::MAX_MODIFIERS - 1; j++) begin
          if (smse_pkg::LIST_AW'(j) >= cmd_i.pos) begin
            list_q[j] <= list_q[j + 1];
          end
        end
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/sticky_modifier_scancode_emitter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sticky_modifier_scancode_emitter_top
// key event to scan code byte emitter with sticky and lockable modifiers
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy then stays
// high until the last result has been issued. One sequencer walks the
// modifier list one entry at a time and shares a single key state ram port,
// so each emitted entry takes a prefix slot and a code slot. A modifier press
// or a modifier release passes through the update and null states, and an out
// of range key goes straight to the null state; a press or a release of any
// other key passes through the update state, its own prefix and code slots and
// one prefix and code slot pair per listed modifier (at most eight). The next
// transaction is taken only once the sequencer is back in its idle state.
// Results come out at most one per cycle on result_valid_o for a single cycle
// each; the receiver cannot stall them and must take every one.
// ----------------------------------------------------------------------------
module sticky_modifier_scancode_emitter_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  smse_pkg::in_item_t  item_i,
  output logic                result_valid_o,
  output smse_pkg::out_item_t result_o
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_UPDATE   = 7'b0000010,
    S_OWN_PFX  = 7'b0000100,
    S_OWN_CODE = 7'b0001000,
    S_ENT_PFX  = 7'b0010000,
    S_ENT_CODE = 7'b0100000,
    S_NULL     = 7'b1000000
  } state_e;

  state_e                         state_q, state_d;
  smse_pkg::in_item_t             item_q;
  logic [1:0]                     final_q, final_d;
  logic                           full_q, full_d;
  logic [smse_pkg::LIST_AW-1:0]   ent_q, ent_d;
  logic [smse_pkg::CNT_W-1:0]     left_q, left_d;
  smse_pkg::out_item_t            result_q, result_d;
  logic                           result_valid_q, result_valid_d;
  logic [smse_pkg::NUM_KEYS-1:0]  valid_q;
  logic                           rd_valid_q;

  logic                           ram_we;
  logic [smse_pkg::KEY_AW-1:0]    ram_waddr;
  logic [1:0]                     ram_wdata;
  logic [smse_pkg::KEY_AW-1:0]    ram_raddr;
  logic [1:0]                     ram_rdata;
  logic [1:0]                     st;
  logic [1:0]                     ns;

  smse_pkg::list_cmd_t            lst_cmd;
  smse_pkg::mod_entry_t           ent;
  smse_pkg::list_status_t         lst;
  smse_pkg::mod_entry_t           new_entry;
  logic                           accept;

  smse_ram #(
    .WIDTH (2),
    .DEPTH (smse_pkg::NUM_KEYS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  smse_mod_list u_mod_list (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (lst_cmd),
    .find_key_i (item_q.key_index),
    .rd_pos_i   (ent_q),
    .rd_entry_o (ent),
    .status_o   (lst)
  );

  assign busy           = (state_q != S_IDLE);
  assign accept         = start && !busy;
  assign st             = rd_valid_q ? ram_rdata : smse_pkg::KS_IDLE;
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  assign new_entry.key_index   = item_q.key_index;
  assign new_entry.scan_code   = item_q.scan_code;
  assign new_entry.prefix_code = item_q.prefix_code;

  // next key state of the addressed key
  always_comb begin
    ns = st;
    if (item_q.action == smse_pkg::ACT_PRESS) begin
      unique case (item_q.key_type)
        smse_pkg::KT_ORDINARY:   ns = (st == smse_pkg::KS_IDLE) ? smse_pkg::KS_PRESSED
                                                                : smse_pkg::KS_IDLE;
        smse_pkg::KT_TOGGLEABLE: ns = (st == smse_pkg::KS_IDLE) ? smse_pkg::KS_LOCKED
                                                                : smse_pkg::KS_IDLE;
        smse_pkg::KT_MODIFIER: begin
          priority if (st == smse_pkg::KS_IDLE) begin
            ns = smse_pkg::KS_PRESSED;
          end else if (st == smse_pkg::KS_PRESSED) begin
            ns = smse_pkg::KS_LOCKED;
          end else begin
            ns = smse_pkg::KS_IDLE;
          end
        end
        smse_pkg::KT_SPARE:      ns = st;
        default:                 ns = st;
      endcase
    end else if (item_q.key_type == smse_pkg::KT_ORDINARY) begin
      ns = (st == smse_pkg::KS_IDLE) ? smse_pkg::KS_PRESSED : smse_pkg::KS_IDLE;
    end
  end

  always_comb begin
    state_d        = state_q;
    final_d        = final_q;
    full_d         = full_q;
    ent_d          = ent_q;
    left_d         = left_q;
    result_valid_d = 1'b0;
    result_d       = '0;
    ram_we         = 1'b0;
    ram_waddr      = smse_pkg::KEY_AW'(item_q.key_index);
    ram_wdata      = ns;
    ram_raddr      = smse_pkg::KEY_AW'(ent.key_index);
    lst_cmd.op     = smse_pkg::LOP_NONE;
    lst_cmd.pos    = lst.hit_pos;
    lst_cmd.entry  = new_entry;

    unique case (state_q)
      S_IDLE: begin
        ram_raddr = smse_pkg::KEY_AW'(item_i.key_index);
        if (accept) begin
          full_d = 1'b0;
          if (32'(item_i.key_index) < smse_pkg::NUM_KEYS) begin
            state_d = S_UPDATE;
          end else begin
            final_d = smse_pkg::KS_IDLE;
            state_d = S_NULL;
          end
        end
      end

      S_UPDATE: begin
        ram_we = 1'b1;
        if (item_q.action == smse_pkg::ACT_PRESS) begin
          final_d = ns;
          if (item_q.key_type == smse_pkg::KT_MODIFIER) begin
            state_d = S_NULL;
            if (ns != st) begin
              priority if (ns == smse_pkg::KS_IDLE) begin
                if (lst.hit) begin
                  lst_cmd.op = smse_pkg::LOP_REMOVE;
                end
              end else if (lst.hit) begin
                lst_cmd.op = smse_pkg::LOP_SET;
              end else if (32'(lst.count) < smse_pkg::MAX_MODIFIERS) begin
                lst_cmd.op = smse_pkg::LOP_APPEND;
              end else begin
                full_d = 1'b1;
              end
            end
          end else begin
            ent_d  = '0;
            left_d = lst.count;
            state_d = (lst.count == '0) ? S_OWN_PFX : S_ENT_PFX;
          end
        end else begin
          if (item_q.key_type == smse_pkg::KT_MODIFIER) begin
            final_d = st;
            state_d = S_NULL;
          end else begin
            final_d = (lst.hit && (ns == smse_pkg::KS_PRESSED)) ? smse_pkg::KS_IDLE : ns;
            state_d = S_OWN_PFX;
          end
        end
      end

      S_OWN_PFX: begin
        if (item_q.prefix_code != 8'h00) begin
          result_valid_d       = 1'b1;
          result_d.code_valid  = 1'b1;
          result_d.code_byte   = item_q.prefix_code;
        end
        state_d = S_OWN_CODE;
      end

      S_OWN_CODE: begin
        result_valid_d      = 1'b1;
        result_d.code_valid = 1'b1;
        if (item_q.action == smse_pkg::ACT_PRESS) begin
          result_d.code_byte   = {1'b0, item_q.scan_code};
          result_d.last_of_run = 1'b1;
          state_d              = S_IDLE;
        end else begin
          result_d.code_byte   = {1'b0, item_q.scan_code} | smse_pkg::BREAK_BIT;
          result_d.last_of_run = (lst.count == '0);
          ent_d                = smse_pkg::LIST_AW'(lst.count - 1'b1);
          left_d               = lst.count;
          state_d              = (lst.count == '0) ? S_IDLE : S_ENT_PFX;
        end
      end

      S_ENT_PFX: begin
        if (ent.prefix_code != 8'h00) begin
          result_valid_d      = 1'b1;
          result_d.code_valid = 1'b1;
          result_d.code_byte  = ent.prefix_code;
        end
        state_d = S_ENT_CODE;
      end

      S_ENT_CODE: begin
        result_valid_d      = 1'b1;
        result_d.code_valid = 1'b1;
        left_d              = left_q - 1'b1;
        if (item_q.action == smse_pkg::ACT_PRESS) begin
          result_d.code_byte = {1'b0, ent.scan_code};
          ent_d              = ent_q + 1'b1;
          state_d            = (left_q == smse_pkg::CNT_W'(1)) ? S_OWN_PFX : S_ENT_PFX;
        end else begin
          result_d.code_byte   = {1'b0, ent.scan_code} | smse_pkg::BREAK_BIT;
          result_d.last_of_run = (left_q == smse_pkg::CNT_W'(1));
          ent_d                = ent_q - 1'b1;
          state_d              = (left_q == smse_pkg::CNT_W'(1)) ? S_IDLE : S_ENT_PFX;
          // a held but unlocked modifier is freed
          if (st == smse_pkg::KS_PRESSED) begin
            ram_we      = 1'b1;
            ram_waddr   = smse_pkg::KEY_AW'(ent.key_index);
            ram_wdata   = smse_pkg::KS_IDLE;
            lst_cmd.op  = smse_pkg::LOP_REMOVE;
            lst_cmd.pos = ent_q;
          end
        end
      end

      S_NULL: begin
        result_valid_d       = 1'b1;
        result_d.last_of_run = 1'b1;
        state_d              = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    result_d.key_state_out = final_d;
    result_d.list_full     = full_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      result_valid_q <= 1'b0;
      valid_q        <= '0;
      rd_valid_q     <= 1'b0;
      full_q         <= 1'b0;
      final_q        <= smse_pkg::KS_IDLE;
      ent_q          <= '0;
      left_q         <= '0;
    end else begin
      state_q        <= state_d;
      result_valid_q <= result_valid_d;
      rd_valid_q     <= valid_q[ram_raddr];
      full_q         <= full_d;
      final_q        <= final_d;
      ent_q          <= ent_d;
      left_q         <= left_d;
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
    if (accept) begin
      item_q <= item_i;
    end
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the sticky modifier scan code emitter
// ----------------------------------------------------------------------------
// Key events are queued up front: a directed opener followed by random
// traffic built mostly from press and release pairs and modifier presses,
// plus some fully random events. A clocked driver presents them with random
// gaps. On each accepted transaction a local model of the key states and
// modifier list predicts the emitted bytes. A clocked monitor compares every
// result with the oldest prediction. A watchdog ends a stuck run.
// ----------------------------------------------------------------------------
module testbench;
  import smse_pkg::*;

  localparam int unsigned STALL_LIMIT = 3000;

  typedef struct {
    in_item_t    ev;
    int unsigned gap;
    bit          drain;
  } key_event_t;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  item = '0;
  logic      result_valid;
  out_item_t result;

  key_event_t  key_events[$];
  out_item_t   pending_bytes[$];
  out_item_t   run_bytes[$];
  logic [1:0]  key_st[NUM_KEYS];
  mod_entry_t  held_mods[$];
  bit          burst_mode;
  int unsigned wait_cnt;
  int unsigned idle_cycles;
  int unsigned mismatch_cnt;

  sticky_modifier_scancode_emitter_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item),
    .result_valid_o(result_valid),
    .result_o      (result)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void add_code(logic [7:0] pfx, logic [7:0] code);
    out_item_t b;
    b = '0;
    b.code_valid = 1'b1;
    if (pfx != 8'h00) begin
      b.code_byte = pfx;
      run_bytes.push_back(b);
    end
    b.code_byte = code;
    run_bytes.push_back(b);
  endfunction

  function automatic void predict_scan_bytes(in_item_t ev);
    logic [1:0] st;
    logic [1:0] ns;
    logic       full;
    int         pos;
    mod_entry_t ent;
    full = 1'b0;
    run_bytes.delete();
    st = key_st[ev.key_index];
    ent.prefix_code = ev.prefix_code;
    ent.scan_code   = ev.scan_code;
    ent.key_index   = ev.key_index;
    if (ev.action == ACT_PRESS) begin
      case (ev.key_type)
        KT_ORDINARY:   ns = (st == KS_IDLE) ? KS_PRESSED : KS_IDLE;
        KT_TOGGLEABLE: ns = (st == KS_IDLE) ? KS_LOCKED : KS_IDLE;
        KT_MODIFIER: begin
          ns = (st == KS_IDLE) ? KS_PRESSED : (st == KS_PRESSED) ? KS_LOCKED : KS_IDLE;
        end
        default:       ns = st;
      endcase
      key_st[ev.key_index] = ns;
      if (ev.key_type == KT_MODIFIER) begin
        pos = -1;
        foreach (held_mods[i]) begin
          if (pos < 0 && held_mods[i].key_index == ev.key_index) pos = i;
        end
        if (ns == KS_IDLE) begin
          if (pos >= 0) held_mods.delete(pos);
        end else if (pos >= 0) begin
          held_mods[pos] = ent;
        end else if (held_mods.size() < MAX_MODIFIERS) begin
          held_mods.push_back(ent);
        end else begin
          full = 1'b1;
        end
      end else begin
        foreach (held_mods[i]) add_code(held_mods[i].prefix_code, {1'b0, held_mods[i].scan_code});
        add_code(ev.prefix_code, {1'b0, ev.scan_code});
      end
    end else if (ev.key_type != KT_MODIFIER) begin
      if (ev.key_type == KT_ORDINARY) begin
        key_st[ev.key_index] = (st == KS_IDLE) ? KS_PRESSED : KS_IDLE;
      end
      add_code(ev.prefix_code, {1'b0, ev.scan_code} | BREAK_BIT);
      for (int i = held_mods.size() - 1; i >= 0; i--) begin
        ent = held_mods[i];
        add_code(ent.prefix_code, {1'b0, ent.scan_code} | BREAK_BIT);
        if (key_st[ent.key_index] == KS_PRESSED) begin
          key_st[ent.key_index] = KS_IDLE;
          held_mods.delete(i);
        end
      end
    end
    if (run_bytes.size() == 0) run_bytes.push_back('0);
    foreach (run_bytes[i]) begin
      run_bytes[i].last_of_run   = (i == run_bytes.size() - 1);
      run_bytes[i].key_state_out = key_st[ev.key_index];
      run_bytes[i].list_full     = full;
      pending_bytes.push_back(run_bytes[i]);
    end
  endfunction

  function automatic void add_event(logic act, logic [6:0] idx, logic [1:0] kt,
                                    logic [6:0] scan, logic [7:0] pfx, bit drain);
    key_event_t e;
    int unsigned r;
    r = $urandom_range(0, 99);
    e.ev.action      = act;
    e.ev.key_index   = idx;
    e.ev.key_type    = kt;
    e.ev.scan_code   = scan;
    e.ev.prefix_code = pfx;
    e.drain          = drain;
    if (burst_mode || r < 40) e.gap = 0;
    else if (r < 85) e.gap = $urandom_range(1, 3);
    else if (r < 95) e.gap = $urandom_range(4, 12);
    else e.gap = $urandom_range(20, 60);
    key_events.push_back(e);
  endfunction

  function automatic logic [7:0] rnd_prefix();
    return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom);
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    logic nxt_start;
    if (!rst_ni) begin
      start    <= 1'b0;
      item     <= '0;
      wait_cnt <= 0;
    end else begin
      nxt_start = start;
      if (start && !busy) begin
        predict_scan_bytes(item);
        nxt_start = 1'b0;
      end
      if (!nxt_start && key_events.size() > 0) begin
        if (wait_cnt < key_events[0].gap) begin
          wait_cnt <= wait_cnt + 1;
        end else if (!key_events[0].drain || pending_bytes.size() == 0) begin
          item      <= key_events[0].ev;
          key_events.pop_front();
          nxt_start = 1'b1;
          wait_cnt  <= 0;
        end
      end
      start <= nxt_start;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && result_valid !== 1'b0) begin
      if (pending_bytes.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected transaction: %p", result);
      end else begin
        if (result !== pending_bytes[0]) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch: expected valid=%0b byte=%02h last=%0b state=%0d full=%0b",
                     pending_bytes[0].code_valid, pending_bytes[0].code_byte,
                     pending_bytes[0].last_of_run, pending_bytes[0].key_state_out,
                     pending_bytes[0].list_full);
            $display("          actual   valid=%0b byte=%02h last=%0b state=%0d full=%0b",
                     result.code_valid, result.code_byte, result.last_of_run,
                     result.key_state_out, result.list_full);
          end
        end
        pending_bytes.pop_front();
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stim_proc
    int unsigned n;
    int unsigned r;
    int unsigned next_drain;
    logic [6:0]  idx;
    logic [6:0]  scan;
    logic [7:0]  pfx;
    bit          drain;
    foreach (key_st[i]) key_st[i] = KS_IDLE;
    mismatch_cnt = 0;
    idle_cycles  = 0;
    burst_mode   = 1'b0;

    // directed opener
    add_event(ACT_RELEASE, 7'd100, KT_MODIFIER, 7'h2A, 8'h00, 1'b0);
    add_event(ACT_PRESS, 7'd0, KT_ORDINARY, 7'h00, 8'h00, 1'b0);
    add_event(ACT_RELEASE, 7'd0, KT_ORDINARY, 7'h00, 8'h00, 1'b0);
    add_event(ACT_PRESS, 7'd127, KT_ORDINARY, 7'h7F, 8'hFF, 1'b0);
    add_event(ACT_RELEASE, 7'd127, KT_ORDINARY, 7'h7F, 8'hFF, 1'b0);
    add_event(ACT_PRESS, 7'd64, KT_TOGGLEABLE, 7'h3A, 8'hE0, 1'b0);
    add_event(ACT_RELEASE, 7'd64, KT_TOGGLEABLE, 7'h3A, 8'hE0, 1'b0);
    add_event(ACT_PRESS, 7'd96, KT_SPARE, 7'h45, 8'hE1, 1'b0);
    add_event(ACT_RELEASE, 7'd96, KT_SPARE, 7'h45, 8'hE1, 1'b0);
    // nine modifiers, the last one finds the list full
    for (int k = 0; k < 9; k++) begin
      add_event(ACT_PRESS, 7'(100 + k), KT_MODIFIER, 7'(8'h1D + k),
                (k % 2) ? 8'hE0 : 8'hE1, 1'b0);
    end
    // second press locks and refreshes the entry
    add_event(ACT_PRESS, 7'd100, KT_MODIFIER, 7'h38, 8'hE0, 1'b0);
    add_event(ACT_PRESS, 7'd1, KT_ORDINARY, 7'h1E, 8'hE0, 1'b0);
    add_event(ACT_RELEASE, 7'd1, KT_ORDINARY, 7'h1E, 8'hE0, 1'b0);
    add_event(ACT_PRESS, 7'd100, KT_MODIFIER, 7'h38, 8'hE0, 1'b0);
    add_event(ACT_PRESS, 7'd108, KT_MODIFIER, 7'h5B, 8'h00, 1'b0);

    // random traffic
    n          = 0;
    next_drain = 0;
    while (n < 410) begin
      burst_mode = (n >= 150 && n < 220);
      drain = (n >= next_drain);
      if (drain) next_drain += 100;
      r    = $urandom_range(0, 99);
      pfx  = rnd_prefix();
      scan = 7'($urandom);
      if (r < 30) begin
        add_event(ACT_PRESS, 7'($urandom_range(100, 111)), KT_MODIFIER, scan, pfx, drain);
        n += 1;
      end else if (r < 35) begin
        add_event(ACT_RELEASE, 7'($urandom_range(100, 111)), KT_MODIFIER, scan, pfx, drain);
        n += 1;
      end else if (r < 65) begin
        idx = 7'($urandom_range(0, 63));
        add_event(ACT_PRESS, idx, KT_ORDINARY, scan, pfx, drain);
        add_event(ACT_RELEASE, idx, KT_ORDINARY, scan, pfx, 1'b0);
        n += 2;
      end else if (r < 75) begin
        idx = 7'($urandom_range(64, 95));
        add_event(ACT_PRESS, idx, KT_TOGGLEABLE, scan, pfx, drain);
        add_event(ACT_RELEASE, idx, KT_TOGGLEABLE, scan, pfx, 1'b0);
        n += 2;
      end else if (r < 82) begin
        idx = 7'($urandom_range(112, 127));
        add_event(ACT_PRESS, idx, KT_SPARE, scan, pfx, drain);
        add_event(ACT_RELEASE, idx, KT_SPARE, scan, pfx, 1'b0);
        n += 2;
      end else begin
        add_event(1'($urandom), 7'($urandom), 2'($urandom), scan, 8'($urandom), drain);
        n += 1;
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (key_events.size() > 0 || start) @(posedge clk_i);
    while (pending_bytes.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (mismatch_cnt == 0 && pending_bytes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/smse_pkg.sv
hw/rtl/smse_ram.sv
hw/rtl/smse_mod_list.sv
hw/rtl/sticky_modifier_scancode_emitter_top.sv
dv/testbench.sv
